### sv/ssdec_pkg.sv
// Package for the stepper step/direction/enable controller.
// Holds constants, queue entry type, register indexes, state enums and a divider step; no dependencies.
package ssdec_pkg;

  localparam int unsigned CountClockHz = 1000000;
  localparam int unsigned PeriodMax    = 65536;
  localparam int unsigned RateInMax    = 1000000;
  localparam int unsigned GapClamp     = 1000;
  localparam int unsigned TicksPerMs   = 10;
  localparam int unsigned PeriodMin    = 2;
  localparam int unsigned RateOutMax   = 524287;

  // Width of the divider operands: wide enough for the count clock.
  localparam int unsigned DivW = $clog2(CountClockHz + 1);

  localparam logic [1:0] RegEnablePolarity   = 2'd0;
  localparam logic [1:0] RegPolarityDeclared = 2'd1;
  localparam logic [1:0] RegStopHold         = 2'd2;
  localparam logic [1:0] RegProgramSource    = 2'd3;

  localparam int unsigned QueueDepth = 2;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic        is_tick;
    logic [19:0] rate_hz;
    logic        direction;
    logic        enable;
    logic [23:0] limit_ms;
    logic [31:0] tick_stamp;
    logic        sensed;
  } item_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkDiv1,
    BkDiv2,
    BkOut
  } back_state_e;

  // Restoring divider step: one quotient bit per call.
  function automatic logic [DivW:0] div_step(input logic [DivW:0] rem,
                                             input logic [DivW-1:0] dvs);
    logic [DivW:0] t;
    t = rem - {1'b0, dvs};
    return t;
  endfunction

endpackage

### sv/ssdec_front.sv
// Front part: accepts items, saturates the rate and pushes them into a short queue.
// Depends on ssdec_pkg.
module ssdec_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action_i,
  input  logic [19:0]          rate_hz_i,
  input  logic                 direction_i,
  input  logic                 enable_i,
  input  logic [23:0]          limit_ms_i,
  input  logic [31:0]          tick_stamp_i,
  input  logic                 sensed_enable_pin_i,
  output logic                 q_valid_o,
  output ssdec_pkg::item_t     q_item_o,
  input  logic                 q_pop_i
);
  import ssdec_pkg::*;

  item_t       mem_q [QueueDepth];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  item_t       it;

  // Classify and saturate the incoming item.
  always_comb begin
    it.is_tick    = action_i;
    it.rate_hz    = (rate_hz_i > 20'(RateInMax)) ? 20'(RateInMax) : rate_hz_i;
    it.direction  = direction_i;
    it.enable     = enable_i;
    it.limit_ms   = limit_ms_i;
    it.tick_stamp = tick_stamp_i;
    it.sensed     = sensed_enable_pin_i;
  end

  assign in_stall  = (cnt_q == 2'(QueueDepth));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rp_q];

  // Queue pointers and fill count.
  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ q_pop_i;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= it;
    end
  end
endmodule

### sv/ssdec_back.sv
// Back part: applies requests and ticks to the controller state, two iterative divisions.
// Depends on ssdec_pkg.
module ssdec_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  ssdec_pkg::item_t q_item_i,
  output logic             q_pop_o,
  input  logic             cfg_pol_i,
  input  logic             cfg_decl_i,
  input  logic             cfg_hold_i,
  input  logic             cfg_prog_i,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             pulse_on_o,
  output logic [15:0]      period_minus_one_o,
  output logic [15:0]      compare_value_o,
  output logic [18:0]      actual_rate_hz_o,
  output logic             direction_level_o,
  output logic             enable_pin_level_o,
  output logic             enable_status_o,
  output logic [23:0]      deadline_left_ms_o,
  output logic [31:0]      mismatch_count_o,
  output logic [31:0]      stop_count_o,
  output logic [31:0]      largest_gap_ticks_o,
  output logic             request_applied_o
);
  import ssdec_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  back_state_e st_q, st_d;

  // Controller state.
  logic        run_q, run_d;
  logic [15:0] per_q, per_d, cmp_q, cmp_d;
  logic [18:0] rate_q, rate_d;
  logic        dir_q, dir_d, pin_q, pin_d, sts_q, sts_d;
  logic [23:0] dl_q, dl_d;
  logic        align_q, align_d, pbad_q, pbad_d;
  logic [31:0] last_q, last_d, mis_q, mis_d, stops_q, stops_d, gap_q, gap_d;
  logic [19:0] crate_q, crate_d;
  logic [1:0]  cde_q, cde_d;
  logic [23:0] clim_q, clim_d;
  logic        cval_q, cval_d;
  logic        appl_q, appl_d;

  // Shared divider.
  logic [DivW-1:0] dvs_q, dvs_d, quo_q, quo_d;
  logic [DivW:0]   rem_q, rem_d, trial;
  logic [CntW-1:0] bit_q, bit_d;

  logic            ov_valid_q, ov_valid_d;
  logic            out_load;

  item_t       it;
  logic        en_nz, cache_hit;
  logic [31:0] dt, dtc;
  logic [6:0]  dm;
  logic [16:0] pc;
  logic        conducting;

  localparam logic [DivW-1:0] Dividend = DivW'(CountClockHz);

  assign it    = q_item_i;
  assign trial = div_step({rem_q[DivW-1:0], Dividend[bit_q[CntW-1:0] - CntW'(1)]}, dvs_q);

  always_comb begin
    st_d = st_q;
    run_d = run_q; per_d = per_q; cmp_d = cmp_q; rate_d = rate_q;
    dir_d = dir_q; pin_d = pin_q; sts_d = sts_q;
    dl_d = dl_q; align_d = align_q; pbad_d = pbad_q; last_d = last_q;
    mis_d = mis_q; stops_d = stops_q; gap_d = gap_q;
    crate_d = crate_q; cde_d = cde_q; clim_d = clim_q; cval_d = cval_q;
    appl_d = appl_q; dvs_d = dvs_q; quo_d = quo_q; rem_d = rem_q; bit_d = bit_q;
    ov_valid_d = ov_valid_q; q_pop_o = 1'b0; out_load = 1'b0;
    en_nz = 1'b0; cache_hit = 1'b0; dt = '0; dtc = '0; dm = '0; pc = '0;
    conducting = 1'b0;
    if (ov_valid_q && !out_stall) ov_valid_d = 1'b0;
    case (st_q)
      BkIdle: begin
        if (q_valid_i && !ov_valid_d) begin
          q_pop_o = 1'b1;
          appl_d  = 1'b0;
          if (it.is_tick) begin
            // Pin check against the intended level.
            if (it.sensed != pin_q) begin
              if (pbad_q) mis_d = mis_q + 32'd1;
              pbad_d = 1'b1;
            end else begin
              pbad_d = 1'b0;
            end
            if (align_q) begin
              last_d  = it.tick_stamp;
              align_d = 1'b0;
            end else begin
              dt     = it.tick_stamp - last_q;
              last_d = it.tick_stamp;
              if (dt > gap_q) gap_d = dt;
              dtc = (dt > 32'(GapClamp)) ? 32'(GapClamp) : dt;
              dm  = 7'(({7'd0, dtc[10:0]} * 18'd205) >> 11);
              if (dl_q != 24'd0 && dm != 7'd0) begin
                if (dl_q > 24'(dm)) begin
                  dl_d = dl_q - 24'(dm);
                end else begin
                  // Deadline safe stop with the rest policy.
                  run_d  = 1'b0;
                  rate_d = '0;
                  if (!cfg_decl_i) begin
                    pin_d = 1'b0;
                  end else begin
                    conducting = cfg_pol_i ? !cfg_hold_i : cfg_hold_i;
                    pin_d = !conducting;
                  end
                  dl_d    = '0;
                  stops_d = stops_q + 32'd1;
                end
              end
            end
            st_d = BkOut;
          end else begin
            cache_hit = cval_q && it.rate_hz == crate_q &&
                        {it.direction, it.enable} == cde_q && it.limit_ms == clim_q;
            if (!cfg_prog_i || cache_hit) begin
              st_d = BkOut;
            end else begin
              appl_d  = 1'b1;
              crate_d = it.rate_hz;
              cde_d   = {it.direction, it.enable};
              clim_d  = it.limit_ms;
              cval_d  = 1'b1;
              dir_d   = it.direction;
              en_nz   = it.enable;
              if (en_nz && !cfg_decl_i) begin
                pin_d = 1'b0;
                sts_d = 1'b1;
              end else begin
                conducting = cfg_pol_i ? !en_nz : en_nz;
                pin_d = !conducting;
                sts_d = 1'b0;
              end
              dl_d    = it.limit_ms;
              align_d = 1'b1;
              if (it.rate_hz == 20'd0) begin
                run_d  = 1'b0;
                rate_d = '0;
                st_d   = BkOut;
              end else begin
                dvs_d = DivW'(it.rate_hz);
                rem_d = '0;
                quo_d = '0;
                bit_d = CntW'(DivW);
                st_d  = BkDiv1;
              end
            end
          end
        end
      end
      BkDiv1, BkDiv2: begin
        // One quotient bit per cycle.
        if (!trial[DivW]) begin
          rem_d = trial;
          quo_d = {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DivW-1:0], Dividend[bit_q - CntW'(1)]};
          quo_d = {quo_q[DivW-2:0], 1'b0};
        end
        bit_d = bit_q - CntW'(1);
        if (bit_q == CntW'(1)) begin
          if (st_q == BkDiv1) begin
            // Clamp the period and start the achieved-rate division.
            if (quo_d < DivW'(PeriodMin)) pc = 17'(PeriodMin);
            else if (quo_d > DivW'(PeriodMax)) pc = 17'(PeriodMax);
            else pc = 17'(quo_d);
            per_d = 16'(pc - 17'd1);
            cmp_d = 16'(pc >> 1);
            run_d = 1'b1;
            dvs_d = DivW'(pc);
            rem_d = '0;
            quo_d = '0;
            bit_d = CntW'(DivW);
            st_d  = BkDiv2;
          end else begin
            rate_d = (quo_d > DivW'(RateOutMax)) ? 19'(RateOutMax) : 19'(quo_d);
            st_d   = BkOut;
          end
        end
      end
      BkOut: begin
        if (!ov_valid_d) begin
          ov_valid_d = 1'b1;
          out_load   = 1'b1;
          st_d = BkIdle;
        end
      end
      default: st_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      run_q <= 1'b0; per_q <= 16'd999; cmp_q <= 16'd500; rate_q <= '0;
      dir_q <= 1'b0; pin_q <= 1'b0; sts_q <= 1'b0;
      dl_q <= '0; align_q <= 1'b1; pbad_q <= 1'b0; last_q <= '0;
      mis_q <= '0; stops_q <= '0; gap_q <= '0;
      crate_q <= '0; cde_q <= '0; clim_q <= '0; cval_q <= 1'b0;
      appl_q <= 1'b0; ov_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      run_q <= run_d; per_q <= per_d; cmp_q <= cmp_d; rate_q <= rate_d;
      dir_q <= dir_d; pin_q <= pin_d; sts_q <= sts_d;
      dl_q <= dl_d; align_q <= align_d; pbad_q <= pbad_d; last_q <= last_d;
      mis_q <= mis_d; stops_q <= stops_d; gap_q <= gap_d;
      crate_q <= crate_d; cde_q <= cde_d; clim_q <= clim_d; cval_q <= cval_d;
      appl_q <= appl_d; ov_valid_q <= ov_valid_d;
    end
  end

  // Divider datapath needs no reset.
  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d; quo_q <= quo_d; rem_q <= rem_d; bit_q <= bit_d;
  end

  // Output register holds the snapshot taken when the result is raised.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pulse_on_o          <= run_q;
      period_minus_one_o  <= per_q;
      compare_value_o     <= cmp_q;
      actual_rate_hz_o    <= rate_q;
      direction_level_o   <= dir_q;
      enable_pin_level_o  <= pin_q;
      enable_status_o     <= sts_q;
      deadline_left_ms_o  <= dl_q;
      mismatch_count_o    <= mis_q;
      stop_count_o        <= stops_q;
      largest_gap_ticks_o <= gap_q;
      request_applied_o   <= appl_q;
    end
  end

  assign out_valid = ov_valid_q;
endmodule

### sv/stepper_step_dir_enable_controller.sv
// Top level of the stepper step/direction/enable controller.
// Depends on ssdec_pkg, ssdec_front and ssdec_back.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/stall   | action, rate, direction, enable, limit, tick
// out     | output    | out_valid/stall  | pulse and pin state, deadline, counters
// cfg     | input     | cfg_valid/ready  | register index, data
//
// A tick or a skipped request passes through the queue, the BkOut state and the output register; an applied
// non-zero request first runs two bit-serial divisions of the count clock (20 steps each).
// The front queue holds two items, so input is taken while the back part works.
// Reset is asynchronous, active low, and restores the controller state at once.
// A stalled result holds in the output register until taken.
module stepper_step_dir_enable_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action_i,
  input  logic [19:0] rate_hz_i,
  input  logic        direction_i,
  input  logic        enable_i,
  input  logic [23:0] limit_ms_i,
  input  logic [31:0] tick_stamp_i,
  input  logic        sensed_enable_pin_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pulse_on_o,
  output logic [15:0] period_minus_one_o,
  output logic [15:0] compare_value_o,
  output logic [18:0] actual_rate_hz_o,
  output logic        direction_level_o,
  output logic        enable_pin_level_o,
  output logic        enable_status_o,
  output logic [23:0] deadline_left_ms_o,
  output logic [31:0] mismatch_count_o,
  output logic [31:0] stop_count_o,
  output logic [31:0] largest_gap_ticks_o,
  output logic        request_applied_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [0:0]  cfg_data_i
);
  import ssdec_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;
  logic  pol_q, decl_q, hold_q, prog_q;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= 1'b0; decl_q <= 1'b0; hold_q <= 1'b1; prog_q <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        RegEnablePolarity:   pol_q  <= cfg_data_i[0];
        RegPolarityDeclared: decl_q <= cfg_data_i[0];
        RegStopHold:         hold_q <= cfg_data_i[0];
        RegProgramSource:    prog_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ssdec_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .action_i, .rate_hz_i, .direction_i,
    .enable_i, .limit_ms_i, .tick_stamp_i, .sensed_enable_pin_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  ssdec_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .cfg_pol_i(pol_q), .cfg_decl_i(decl_q), .cfg_hold_i(hold_q), .cfg_prog_i(prog_q),
    .out_valid, .out_stall, .pulse_on_o, .period_minus_one_o, .compare_value_o,
    .actual_rate_hz_o, .direction_level_o, .enable_pin_level_o, .enable_status_o,
    .deadline_left_ms_o, .mismatch_count_o, .stop_count_o, .largest_gap_ticks_o,
    .request_applied_o
  );
endmodule

### sv/ssdec_checker.sv
// Port-level checker for the stepper controller, bound to the top level.
// Depends on nothing beyond the top-level ports.
module ssdec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_stall,
  input logic        pulse_on_o,
  input logic [15:0] period_minus_one_o,
  input logic [15:0] compare_value_o,
  input logic [18:0] actual_rate_hz_o
);
  // A held result stays valid and its period stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(period_minus_one_o))
    else $error("result changed while stalled");

  // Stopped pulses report zero rate.
  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !pulse_on_o |-> actual_rate_hz_o == 19'd0)
    else $error("rate non-zero while stopped");

  // Running pulses report a non-zero rate and a half period.
  a_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && pulse_on_o |-> actual_rate_hz_o != 19'd0 &&
      compare_value_o == 16'((17'(period_minus_one_o) + 17'd1) >> 1))
    else $error("compare not half period");
endmodule

bind stepper_step_dir_enable_controller ssdec_checker u_ssdec_checker (
  .clk_i, .rst_ni, .out_valid, .out_stall, .pulse_on_o, .period_minus_one_o,
  .compare_value_o, .actual_rate_hz_o
);

### sim/ssdec_checker.sv
// Checker for the stepper step/direction/enable controller: watches the channels,
// predicts every result and compares it. Depends on ssdec_pkg.
module ssdec_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action_i,
  input  logic [19:0] rate_hz_i,
  input  logic        direction_i,
  input  logic        enable_i,
  input  logic [23:0] limit_ms_i,
  input  logic [31:0] tick_stamp_i,
  input  logic        sensed_enable_pin_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        pulse_on_o,
  input  logic [15:0] period_minus_one_o,
  input  logic [15:0] compare_value_o,
  input  logic [18:0] actual_rate_hz_o,
  input  logic        direction_level_o,
  input  logic        enable_pin_level_o,
  input  logic        enable_status_o,
  input  logic [23:0] deadline_left_ms_o,
  input  logic [31:0] mismatch_count_o,
  input  logic [31:0] stop_count_o,
  input  logic [31:0] largest_gap_ticks_o,
  input  logic        request_applied_o,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [0:0]  cfg_data_i,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssdec_pkg::*;

  typedef struct packed {
    logic        pulse_on;
    logic [15:0] period_m1;
    logic [15:0] compare;
    logic [18:0] rate;
    logic        dir;
    logic        pin;
    logic        status;
    logic [23:0] deadline;
    logic [31:0] mismatches;
    logic [31:0] stops;
    logic [31:0] max_gap;
    logic        applied;
  } motor_view_t;

  motor_view_t expected_views[$];

  // Configuration copy.
  logic pol, declared, hold, prog_src;
  // Controller state copy.
  logic        running, dir_q, en_req, intent, status_q, align, prev_bad, cache_ok;
  logic [15:0] period_q, compare_q;
  logic [19:0] rate_q, cache_rate;
  logic [23:0] deadline_q, cache_lim;
  logic [31:0] last_tick, mism_q, stops_q, gap_q;
  logic [1:0]  cache_de;

  function automatic logic conduct_level(logic energized);
    logic c;
    c = (pol == 1'b0) ? energized : ~energized;
    return ~c;
  endfunction

  task automatic program_rate(input logic [19:0] hz);
    int unsigned p, r;
    if (hz == 0) begin
      running = 1'b0;
      rate_q  = '0;
    end else begin
      p = CountClockHz / hz;
      if (p < PeriodMin) p = PeriodMin;
      if (p > PeriodMax) p = PeriodMax;
      period_q  = 16'(p - 1);
      compare_q = 16'(p / 2);
      running   = 1'b1;
      r = CountClockHz / p;
      rate_q = 20'((r > RateOutMax) ? RateOutMax : r);
    end
  endtask

  task automatic rest_enable();
    if (!declared) begin
      en_req = 1'b0;
      intent = 1'b0;
    end else begin
      en_req = hold;
      intent = conduct_level(en_req);
    end
  endtask

  task automatic motion_request(input logic [19:0] hz_in, input logic d, input logic e,
                                input logic [23:0] lim, output logic applied);
    logic [19:0] hz;
    hz = (hz_in > RateInMax) ? 20'(RateInMax) : hz_in;
    applied = 1'b0;
    if (prog_src && !(cache_ok && hz == cache_rate && {d, e} == cache_de && lim == cache_lim))
    begin
      applied    = 1'b1;
      cache_rate = hz;
      cache_de   = {d, e};
      cache_lim  = lim;
      cache_ok   = 1'b1;
      dir_q      = d;
      if (e && !declared) begin
        en_req = 1'b0;
        intent = 1'b0;
        status_q = 1'b1;
      end else begin
        en_req = e;
        intent = conduct_level(e);
        status_q = 1'b0;
      end
      program_rate(hz);
      deadline_q = lim;
      align = 1'b1;
    end
  endtask

  task automatic time_tick(input logic [31:0] now, input logic sensed);
    logic [31:0] dt, dm;
    if (sensed != intent) begin
      if (prev_bad) mism_q = mism_q + 1;
      prev_bad = 1'b1;
    end else begin
      prev_bad = 1'b0;
    end
    if (align) begin
      last_tick = now;
      align = 1'b0;
    end else begin
      dt = now - last_tick;
      last_tick = now;
      if (dt > gap_q) gap_q = dt;
      if (dt > GapClamp) dt = GapClamp;
      dm = dt / TicksPerMs;
      if (deadline_q != 0 && dm != 0) begin
        if (deadline_q > dm) begin
          deadline_q = deadline_q - 24'(dm);
        end else begin
          program_rate('0);
          rest_enable();
          deadline_q = '0;
          stops_q = stops_q + 1;
        end
      end
    end
  endtask

  // Prediction on accepted items and configuration writes; comparison on results.
  always @(posedge clk_i or negedge rst_ni) begin
    motor_view_t got, want;
    logic applied;
    if (!rst_ni) begin
      pol = 0; declared = 0; hold = 1; prog_src = 0;
      running = 0; period_q = 16'd999; compare_q = 16'd500; rate_q = 0;
      dir_q = 0; en_req = 0; intent = 0; status_q = 0; deadline_q = 0;
      align = 1; last_tick = 0; prev_bad = 0; mism_q = 0; stops_q = 0; gap_q = 0;
      cache_rate = 0; cache_de = 0; cache_lim = 0; cache_ok = 0;
      expected_views.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_i)
          RegEnablePolarity:   pol = cfg_data_i[0];
          RegPolarityDeclared: declared = cfg_data_i[0];
          RegStopHold:         hold = cfg_data_i[0];
          RegProgramSource:    prog_src = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{pulse_on_o, period_minus_one_o, compare_value_o, actual_rate_hz_o,
                direction_level_o, enable_pin_level_o, enable_status_o,
                deadline_left_ms_o, mismatch_count_o, stop_count_o,
                largest_gap_ticks_o, request_applied_o};
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        applied = 1'b0;
        if (!action_i) motion_request(rate_hz_i, direction_i, enable_i, limit_ms_i, applied);
        else time_tick(tick_stamp_i, sensed_enable_pin_i);
        expected_views.push_back('{running, period_q, compare_q, rate_q[18:0], dir_q,
                                   intent, status_q, deadline_q, mism_q, stops_q, gap_q,
                                   applied});
      end
      pending = expected_views.size();
    end
  end
endmodule

### sim/tb_stepper_step_dir_enable_controller.sv
// Testbench top for the stepper step/direction/enable controller: drives items and
// configuration, idles both sides. Depends on ssdec_pkg, ssdec_tb_checker and the RTL.
module tb_stepper_step_dir_enable_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import ssdec_pkg::*;

  logic        clk_i = 0, rst_ni = 0;
  logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic        action_i = 0, direction_i = 0, enable_i = 0, sensed_enable_pin_i = 0;
  logic [19:0] rate_hz_i = 0;
  logic [23:0] limit_ms_i = 0;
  logic [31:0] tick_stamp_i = 0;
  logic        pulse_on_o, direction_level_o, enable_pin_level_o, enable_status_o;
  logic        request_applied_o;
  logic [15:0] period_minus_one_o, compare_value_o;
  logic [18:0] actual_rate_hz_o;
  logic [23:0] deadline_left_ms_o;
  logic [31:0] mismatch_count_o, stop_count_o, largest_gap_ticks_o;
  logic        cfg_valid = 0, cfg_ready;
  logic [1:0]  cfg_index_i = 0;
  logic [0:0]  cfg_data_i = 0;
  int          fail_count, pending;
  bit          calm = 0;
  logic [31:0] clock_now = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  stepper_step_dir_enable_controller DUT (.*);
  ssdec_tb_checker u_checker (.*);

  // Result side stalls at random, except during the calm stretch.
  always @(negedge clk_i) out_stall <= !calm && ($urandom_range(99) < 14);

  // One register write; valid is then dropped on the write channel before the task returns.
  task automatic write_reg(input logic [1:0] idx, input logic val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid   <= 1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  // Valid stays high from one item to the next unless an idle cycle comes between.
  task automatic send_item(input logic act, input logic [19:0] hz, input logic d,
                           input logic e, input logic [23:0] lim, input logic [31:0] now,
                           input logic sensed);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 0;
      @(negedge clk_i);
    end
    action_i <= act; rate_hz_i <= hz; direction_i <= d; enable_i <= e;
    limit_ms_i <= lim; tick_stamp_i <= now; sensed_enable_pin_i <= sensed;
    in_valid <= 1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic send_request(input logic [19:0] hz, input logic d, input logic e,
                              input logic [23:0] lim);
    send_item(0, hz, d, e, lim, $urandom, $urandom);
  endtask

  task automatic send_tick(input logic [31:0] gap, input logic sensed);
    clock_now = clock_now + gap;
    send_item(1, $urandom, $urandom, $urandom, $urandom, clock_now, sensed);
  endtask

  function automatic logic [19:0] pick_rate();
    case ($urandom_range(7))
      0: return 0;
      1: return $urandom_range(20, 1);
      2: return $urandom_range(1048575, 900000);
      3: return $urandom_range(600000, 400000);
      default: return $urandom_range(100000, 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_gap();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(3000, 900);
      2: return $urandom_range(9);
      default: return $urandom_range(120, 5);
    endcase
  endfunction

  initial begin
    int n;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: requests ignored while the program source is off, then refused enable.
    send_request(1000, 1, 1, 5);
    send_tick(0, 0);
    settle();
    write_reg(RegProgramSource, 1);
    send_request(1000, 1, 1, 5);
    send_request(1000, 1, 1, 5);
    send_tick(7, 1);
    send_tick(20, 1);
    send_tick(40, 1);
    settle();
    write_reg(RegPolarityDeclared, 1);
    write_reg(RegEnablePolarity, 1);
    write_reg(RegStopHold, 0);
    send_request(20'hFFFFF, 0, 1, 24'hFFFFFF);
    send_request(1, 1, 1, 3);
    send_request(16, 0, 0, 0);
    send_request(0, 1, 1, 2);
    send_tick(32'hFFFFFFF0, 0);
    send_tick(32'h20, 1);
    send_tick(32'hFFFFFFFF, 1);
    send_tick(5000, 0);
    send_request(500000, 0, 1, 1);
    send_tick(1, 1);
    send_tick(15, 0);
    settle();

    // Random phases over several configurations.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(RegEnablePolarity, $urandom);
      write_reg(RegPolarityDeclared, phase != 0 ? $urandom_range(3) != 0 : 0);
      write_reg(RegStopHold, $urandom);
      write_reg(RegProgramSource, phase == 7 ? 0 : $urandom_range(5) != 0);
      calm = (phase == 3);
      n = 0;
      while (n < 215) begin
        if ($urandom_range(3) == 0) begin
          send_request(pick_rate(), $urandom, $urandom,
                       $urandom_range(1) ? $urandom_range(30) : $urandom);
        end else begin
          send_tick(pick_gap(), $urandom_range(3) == 0 ? $urandom : DUT.enable_pin_level_o);
        end
        n++;
      end
      calm = 0;
      settle();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
